// File: src/ios_pkg.sv
// Shared constants, operation codes and cell interface types for the ordered set.
`default_nettype none

package ios_pkg;

    localparam int CAPACITY = 64;

    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    // Cell index and member count widths follow the capacity.
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_READ     = 3'd4
    } ios_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic               load;
        logic [VALUE_W-1:0] in_value;
        logic [WIDE_W-1:0]  in_position;
        logic [CNT_W-1:0]   count;
        logic               wr_en;
        logic [VALUE_W-1:0] wr_value;
        logic               shift_en;
        logic [IDX_W-1:0]   rm_index;
    } ios_ctrl_t;

    // Returned by each cell to the controller.
    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] rd_data;
    } ios_cell_t;

endpackage

`default_nettype wire

// File: src/insertion_ordered_set.sv
// Insertion-ordered set of distinct 32-bit values kept in a row of storage cells.
// Timing: the accept edge latches the per-cell match; once the output register is free or
// being drained, the cells and the output register update together.
// A new request is not accepted until the current one has made its match-then-update pass.
// The next request is taken while a response still waits in the output register.
// Reset (rst_n, asynchronous, active low) empties the set and drops any pending response.
`default_nettype none

module insertion_ordered_set (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [ios_pkg::OP_W-1:0]           op,
    input  logic signed [ios_pkg::VALUE_W-1:0] value,
    input  logic [ios_pkg::POS_W-1:0]          position,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic                               ok,
    output logic signed [ios_pkg::VALUE_W-1:0] read_value,
    output logic [ios_pkg::COUNT_W-1:0]        count,
    output logic                               rejected_full
);
    import ios_pkg::*;

    logic                exec_reg;
    logic                exec_next;
    logic [OP_W-1:0]     op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [WIDE_W-1:0]   pos_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic                ok_reg;
    logic                ok_next;
    logic [VALUE_W-1:0]  rd_reg;
    logic [VALUE_W-1:0]  rd_next;
    logic                full_reg;
    logic                full_next;
    logic [CNT_W-1:0]    rsp_count_reg;

    logic                load;
    logic                go;
    logic                any_hit;
    logic                set_full;
    logic                pos_valid;
    logic [IDX_W-1:0]    hit_index;
    logic [VALUE_W-1:0]  rd_any;
    logic                wr_en;
    logic                shift_en;

    ios_ctrl_t           ctrl;
    ios_cell_t           cell_status [CAPACITY];
    logic [VALUE_W-1:0]  cell_entry  [CAPACITY];
    logic [CAPACITY-1:0] hit_vec;

    // Encode the single matching cell; values in the set are distinct.
    function automatic logic [IDX_W-1:0] encode_hit(input logic [CAPACITY-1:0] hits);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hits[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    assign load      = req_valid && !exec_reg;
    assign req_stall = exec_reg;
    assign go        = exec_reg && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_vec[i] = cell_status[i].hit;
            rd_any     = rd_any | cell_status[i].rd_data;
        end
    end

    assign any_hit   = |hit_vec;
    assign hit_index = encode_hit(hit_vec);
    assign set_full  = (count_reg == CNT_W'(CAPACITY));
    assign pos_valid = pos_reg < WIDE_W'(count_reg);

    always_comb
    begin
        wr_en      = 1'b0;
        shift_en   = 1'b0;
        count_next = count_reg;
        ok_next    = 1'b0;
        rd_next    = '0;
        full_next  = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                if (!any_hit)
                begin
                    if (set_full)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (any_hit)
                begin
                    shift_en   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    ok_next    = 1'b1;
                end
            end
            OP_CONTAINS:
            begin
                ok_next = any_hit;
            end
            OP_CLEAR:
            begin
                count_next = '0;
                ok_next    = 1'b1;
            end
            OP_READ:
            begin
                if (pos_valid)
                begin
                    ok_next = 1'b1;
                    rd_next = rd_any;
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    assign ctrl.load        = load;
    assign ctrl.in_value    = value;
    assign ctrl.in_position = WIDE_W'(position);
    assign ctrl.count       = count_reg;
    assign ctrl.wr_en       = go && wr_en;
    assign ctrl.wr_value    = value_reg;
    assign ctrl.shift_en    = go && shift_en;
    assign ctrl.rm_index    = hit_index;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VALUE_W-1:0] upper;
        if (g == CAPACITY - 1)
        begin : g_top
            assign upper = cell_entry[g];
        end
        else
        begin : g_mid
            assign upper = cell_entry[g+1];
        end

        ios_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .index       (IDX_W'(g)),
            .upper_entry (upper),
            .entry       (cell_entry[g]),
            .status      (cell_status[g])
        );
    end

    always_comb
    begin
        exec_next = exec_reg;
        if (load)
        begin
            exec_next = 1'b1;
        end
        else if (go)
        begin
            exec_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            exec_reg      <= exec_next;
            rsp_valid_reg <= rsp_valid_next;
            if (go)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the request and the response payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg    <= op;
            value_reg <= value;
            pos_reg   <= WIDE_W'(position);
        end
        if (go)
        begin
            ok_reg        <= ok_next;
            rd_reg        <= rd_next;
            full_reg      <= full_next;
            rsp_count_reg <= count_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign ok            = ok_reg;
    assign read_value    = rd_reg;
    assign count         = COUNT_W'(rsp_count_reg);
    assign rejected_full = full_reg;

endmodule

`default_nettype wire

// File: src/ios_cell.sv
// One storage cell of the ordered set: entry, local match and neighbor shift.
`default_nettype none

module ios_cell (
    input  logic                        clk,
    input  ios_pkg::ios_ctrl_t          ctrl,
    input  logic [ios_pkg::IDX_W-1:0]   index,
    input  logic [ios_pkg::VALUE_W-1:0] upper_entry,
    output logic [ios_pkg::VALUE_W-1:0] entry,
    output ios_pkg::ios_cell_t          status
);
    import ios_pkg::*;

    logic [VALUE_W-1:0] entry_reg;
    logic               hit_reg;
    logic               sel_reg;
    logic [WIDE_W-1:0]  index_wide;
    logic               member;

    assign index_wide = WIDE_W'(index);
    assign member     = index_wide < WIDE_W'(ctrl.count);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            hit_reg <= member && (entry_reg == ctrl.in_value);
            sel_reg <= (index_wide == ctrl.in_position);
        end
        // Close the gap: every cell at or above the removed one takes its upper neighbor.
        if (ctrl.shift_en && (index >= ctrl.rm_index))
        begin
            entry_reg <= upper_entry;
        end
        else if (ctrl.wr_en && (index_wide == WIDE_W'(ctrl.count)))
        begin
            entry_reg <= ctrl.wr_value;
        end
    end

    assign entry          = entry_reg;
    assign status.hit     = hit_reg;
    assign status.rd_data = sel_reg ? entry_reg : '0;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the insertion-ordered set: directed table, random ops, stalls.
`default_nettype none

module tb_top;
    import ios_pkg::*;

    localparam int GAP_MAX      = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 8;

    // Op codes the block does not decode.
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    localparam logic [VALUE_W-1:0] V_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] V_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] V_ZERO = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] V_ONES = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] V_ALT  = 32'h5555_5555;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] rd;
        logic [COUNT_W-1:0] cnt;
        logic               full;
    } set_rsp_t;

    typedef struct {
        logic [OP_W-1:0]    o;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0]   p;
        bit                 typed;
        set_rsp_t           want;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [OP_W-1:0]           op = OP_ADD;
    logic signed [VALUE_W-1:0] value = '0;
    logic [POS_W-1:0]          position = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic                      ok;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
    logic                      rejected_full;

    // Shadow copy of the set, in order of first membership.
    logic [VALUE_W-1:0] shadow [CAPACITY];
    int                 shadow_size = 0;

    set_rsp_t  pending_rsp [$];
    plan_row_t plan [$];
    set_rsp_t  got_rsp;
    set_rsp_t  want_rsp;
    bit        quiet = 1'b0;
    bit        hold_done = 1'b0;
    int        req_sent = 0;
    int        rsp_seen = 0;
    int        errors = 0;
    int        idle_cycles = 0;

    insertion_ordered_set dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .op            (op),
        .value         (value),
        .position      (position),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .ok            (ok),
        .read_value    (read_value),
        .count         (count),
        .rejected_full (rejected_full)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic set_rsp_t apply_set_op(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v,
                                              logic [POS_W-1:0] p);
        set_rsp_t r;
        int       hit;
        r   = '0;
        hit = -1;
        for (int i = 0; i < shadow_size; i++)
        begin
            if (hit < 0 && shadow[i] == v)
                hit = i;
        end
        case (o)
            OP_ADD:
            begin
                if (hit < 0)
                begin
                    if (shadow_size >= CAPACITY)
                        r.full = 1'b1;
                    else
                    begin
                        shadow[shadow_size] = v;
                        shadow_size++;
                        r.ok = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    // Close the gap by shifting later members down.
                    for (int j = hit; j < shadow_size - 1; j++)
                        shadow[j] = shadow[j + 1];
                    shadow_size--;
                    r.ok = 1'b1;
                end
            end
            OP_CONTAINS:
                r.ok = (hit >= 0);
            OP_CLEAR:
            begin
                shadow_size = 0;
                r.ok        = 1'b1;
            end
            OP_READ:
            begin
                if (int'(p) < shadow_size)
                begin
                    r.rd = shadow[p];
                    r.ok = 1'b1;
                end
            end
            default:
                ;
        endcase
        r.cnt = COUNT_W'(shadow_size);
        return r;
    endfunction

    function automatic string rsp_text(set_rsp_t r);
        return $sformatf("ok=%0b read_value=%0h count=%0d rejected_full=%0b",
                         r.ok, r.rd, r.cnt, r.full);
    endfunction

    function automatic void plan_typed(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v,
                                       logic [POS_W-1:0] p, logic k, logic [VALUE_W-1:0] rd,
                                       logic [COUNT_W-1:0] cnt, logic full);
        plan_row_t row;
        row.o     = o;
        row.v     = v;
        row.p     = p;
        row.typed = 1'b1;
        row.want  = {k, rd, cnt, full};
        plan.push_back(row);
    endfunction

    function automatic void plan_predicted(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v,
                                           logic [POS_W-1:0] p);
        plan_row_t row;
        row.o     = o;
        row.v     = v;
        row.p     = p;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 4 && shadow_size > 0)
            return shadow[$urandom_range(0, shadow_size - 1)];
        if (k < 7)
        begin
            case ($urandom_range(0, 5))
                0: return V_MIN;
                1: return V_MAX;
                2: return V_ZERO;
                3: return V_ONES;
                4: return V_ALT;
                default: return VALUE_W'($urandom_range(0, 15));
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30)
            return OP_ADD;
        if (k < 50)
            return OP_REMOVE;
        if (k < 68)
            return OP_CONTAINS;
        if (k < 90)
            return OP_READ;
        if (k < 93)
            return OP_CLEAR;
        case ($urandom_range(0, 2))
            0: return OP_SPARE_LO;
            1: return OP_SPARE_MID;
            default: return OP_SPARE_HI;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        if (shadow_size > 0 && $urandom_range(0, 9) < 7)
            return POS_W'($urandom_range(0, shadow_size - 1));
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    // Offer one request after a random gap; predict its response once accepted.
    task automatic issue_req(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v, logic [POS_W-1:0] p,
                             bit typed, set_rsp_t typed_rsp);
        int       gap;
        set_rsp_t pred;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op        <= o;
        value     <= v;
        position  <= p;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        pred = apply_set_op(o, v, p);
        pending_rsp.push_back(typed ? typed_rsp : pred);
        req_sent++;
    endtask

    initial
    begin
        int rand_base;
        int kind;
        plan_typed(OP_READ, V_ZERO, 0, 1'b0, V_ZERO, 0, 1'b0);
        plan_typed(OP_CONTAINS, V_MIN, 0, 1'b0, V_ZERO, 0, 1'b0);
        plan_typed(OP_REMOVE, V_ONES, 0, 1'b0, V_ZERO, 0, 1'b0);
        plan_typed(OP_ADD, V_MIN, 0, 1'b1, V_ZERO, 1, 1'b0);
        plan_typed(OP_ADD, V_MAX, 0, 1'b1, V_ZERO, 2, 1'b0);
        plan_typed(OP_ADD, V_ZERO, 0, 1'b1, V_ZERO, 3, 1'b0);
        plan_typed(OP_ADD, V_ONES, 63, 1'b1, V_ZERO, 4, 1'b0);
        plan_typed(OP_ADD, V_MIN, 0, 1'b0, V_ZERO, 4, 1'b0);
        plan_typed(OP_READ, V_ZERO, 0, 1'b1, V_MIN, 4, 1'b0);
        plan_typed(OP_READ, V_ZERO, 3, 1'b1, V_ONES, 4, 1'b0);
        plan_typed(OP_READ, V_ONES, 63, 1'b0, V_ZERO, 4, 1'b0);
        plan_typed(OP_READ, V_ZERO, 4, 1'b0, V_ZERO, 4, 1'b0);
        plan_typed(OP_CONTAINS, V_MAX, 0, 1'b1, V_ZERO, 4, 1'b0);
        plan_typed(OP_REMOVE, V_MIN, 0, 1'b1, V_ZERO, 3, 1'b0);
        plan_predicted(OP_READ, V_ZERO, 0);
        plan_predicted(OP_REMOVE, V_ZERO, 0);
        plan_typed(OP_REMOVE, V_ZERO, 0, 1'b0, V_ZERO, 2, 1'b0);
        plan_typed(OP_SPARE_LO, V_MAX, 63, 1'b0, V_ZERO, 2, 1'b0);
        plan_typed(OP_SPARE_MID, V_ZERO, 0, 1'b0, V_ZERO, 2, 1'b0);
        plan_typed(OP_SPARE_HI, V_ONES, 63, 1'b0, V_ZERO, 2, 1'b0);
        plan_predicted(OP_ADD, V_ALT, 0);
        plan_predicted(OP_READ, V_ZERO, 2);
        plan_typed(OP_CLEAR, V_ONES, 63, 1'b1, V_ZERO, 0, 1'b0);
        plan_typed(OP_READ, V_ZERO, 0, 1'b0, V_ZERO, 0, 1'b0);
        plan_typed(OP_CONTAINS, V_ONES, 0, 1'b0, V_ZERO, 0, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            issue_req(plan[i].o, plan[i].v, plan[i].p, plan[i].typed, plan[i].want);

        rand_base = req_sent;
        while (req_sent - rand_base < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 9);
            if (kind < 2)
            begin
                // Fill to capacity, then push past it.
                while (shadow_size < CAPACITY)
                    issue_req(OP_ADD, $urandom, pick_pos(), 1'b0, '0);
                repeat (4)
                    issue_req(OP_ADD, pick_value(), pick_pos(), 1'b0, '0);
                issue_req(OP_READ, $urandom, POS_W'(CAPACITY - 1), 1'b0, '0);
                issue_req(OP_CONTAINS, pick_value(), pick_pos(), 1'b0, '0);
            end
            else if (kind < 7)
            begin
                repeat (40)
                    issue_req(pick_op(), pick_value(), pick_pos(), 1'b0, '0);
            end
            else if (kind == 7)
            begin
                for (int i = 0; i <= shadow_size && i < (1 << POS_W); i++)
                    issue_req(OP_READ, $urandom, POS_W'(i), 1'b0, '0);
            end
            else
            begin
                repeat (20)
                begin
                    if (shadow_size > 0)
                        issue_req(OP_REMOVE, shadow[$urandom_range(0, shadow_size - 1)],
                                  pick_pos(), 1'b0, '0);
                    else
                        issue_req(OP_REMOVE, pick_value(), pick_pos(), 1'b0, '0);
                end
            end
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Response side: random holds per response, plus one long hold to back up the block.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && rsp_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
                if (gap > 0)
                begin
                    rsp_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                    rsp_stall <= 1'b0;
                end
            end
            do
                @(posedge clk);
            while (!(rsp_valid && !rsp_stall));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen++;
            got_rsp = {ok, read_value, count, rejected_full};
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response: expected none, got %s",
                         $time, rsp_text(got_rsp));
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (got_rsp !== want_rsp)
                begin
                    errors++;
                    $display("%0t: mismatch: expected %s, got %s",
                             $time, rsp_text(want_rsp), rsp_text(got_rsp));
                end
            end
        end
    end

    // Drop the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no request or response moved", $time);
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
